@@ hw/rtl/wmie_pkg.sv @@
// Shared types, constants and opcodes of the word machine instruction executor.
`default_nettype none
package wmie_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned REG_COUNT = 256;
	// data memory depth, a power of two: addresses are taken modulo by masking
	localparam int unsigned MEM_WORDS = 65536;
	localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
	localparam int unsigned DIV_CNT_W = $clog2(WORD_W);

	localparam logic [7:0] SP_DATA      = 8'(REG_COUNT - 4);
	localparam logic [7:0] SP_SAVE      = 8'(REG_COUNT - 3);
	localparam logic [7:0] SP_CALL      = 8'(REG_COUNT - 2);
	localparam logic [7:0] CONSOLE_PORT = 8'd78;
	localparam logic [WORD_W-1:0] SIGN_BIT = 32'h8000_0000;

	// divider request and response
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] quot;
		logic [WORD_W-1:0] rem;
	} div_res_t;

	typedef enum logic [5:0] {
		OP_ADD_RRR, OP_ADD_RRL, OP_SUB_RRR, OP_SUB_RRL, OP_SUB_RLR, OP_RSH, OP_LSH, OP_INC,
		OP_DEC, OP_XOR_RRR, OP_XOR_RRL, OP_OR_RRR, OP_OR_RRL, OP_AND_RRR, OP_AND_RRL,
		OP_MUL_RRR, OP_MUL_RRL, OP_DIV_RRR, OP_DIV_RRL, OP_DIV_RLR, OP_MOD_RRR, OP_MOD_RRL,
		OP_MOD_RLR, OP_IMM, OP_MOV, OP_LOAD_L, OP_LOAD_R, OP_ST_LL, OP_ST_LR, OP_ST_RL,
		OP_ST_RR, OP_PUSH_R, OP_PUSH_L, OP_POP, OP_SAVE, OP_RESTORE, OP_JMP_L, OP_JMP_R,
		OP_BC_L, OP_BC_R, OP_BNC_L, OP_BNC_R, OP_BZ_L, OP_BZ_R, OP_BNZ_L, OP_BNZ_R,
		OP_BNN_L, OP_BNN_R, OP_BN_L, OP_BN_R, OP_CMP_RR, OP_CMP_RL, OP_CMP_LR, OP_CALL_L,
		OP_CALL_R, OP_RET, OP_HALT, OP_IN, OP_OUT_R, OP_OUT_L, OP_SHL_RRL, OP_SHL_RRR,
		OP_SHR_RRL, OP_SHR_RRR
	} opcode_t;

endpackage
`default_nettype wire

@@ hw/rtl/word_machine_instruction_executor.sv @@
// Top level: sequencer executing one word machine instruction per input beat.
//
// channel  dir  beat contents
// s_*      in   one instruction: opcode, three operand words, keyboard byte
// m_*      out  one result: next address, halt, print, key, fault, flags
//
// An instruction steps through R1, R2 and R3 on the serial register file read port,
// then EX and DONE; load, pop, restore, return and in add an LD step, multiply a
// MUL step, and divide and modulo by a nonzero divisor wait in DIV on the
// one-bit-per-cycle divider. After reset a clearing pass zeroes data memory,
// registers and port latches; no instruction is accepted meanwhile.
// A result waiting on m_tready holds the next instruction at its last step.
`default_nettype none
module word_machine_instruction_executor (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// command[5:0], operand_a[37:6], operand_b[69:38], operand_c[101:70], key_code[109:102]
	input  wire logic [111:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// next_address[31:0], halted[32], print_valid[33], print_value[65:34], key_taken[66],
	// divide_fault[67], flag_zero[68], flag_carry[69], flag_negative[70]
	output logic [71:0]       m_tdata
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_R1, S_R2, S_R3, S_EX, S_LD, S_MUL, S_DIV, S_DONE
	} state_t;

	localparam int unsigned AW = wmie_pkg::MEM_AW;

	state_t                state_q;
	logic [AW-1:0]         clr_q;
	wmie_pkg::opcode_t     op_q;
	logic [31:0]           a_q, b_q, c_q;
	logic [7:0]            key_q;
	logic [31:0]           ra_q, rb_q;
	logic [31:0]           pc_q, next_q;
	logic [63:0]           prod_q;
	logic                  fz_q, fc_q, fn_q;
	logic                  halt_q, pv_q, kt_q, fault_q;
	logic [31:0]           pval_q;
	logic                  m_tvalid_q;
	logic [71:0]           m_tdata_q;

	// memories and their ports
	logic [31:0]           rf_mem [wmie_pkg::REG_COUNT];
	logic [31:0]           pl_mem [256];
	logic [31:0]           dm_mem [wmie_pkg::MEM_WORDS];
	logic [31:0]           rf_rdata_q, pl_rdata_q, dm_rdata_q;
	logic                  rf_we, pl_we, dm_we;
	logic [7:0]            rf_raddr, rf_waddr, pl_addr;
	logic [AW-1:0]         dm_addr;
	logic [31:0]           rf_wdata, pl_wdata, dm_wdata;

	wmie_pkg::div_req_t    div_req;
	wmie_pkg::div_res_t    div_res;

	// decode and operand selection
	logic [7:0]            idx1, idx2;
	logic [31:0]           xv, yv, alu_r, push_val, pop_ptr, target, out_v;
	logic                  alu_cy, is_alu, is_cmp, is_mul, is_div, is_mod, take, console;
	logic [63:0]           shl_wide;
	logic [2:0]            len;
	logic                  clr_lo, flag_we, flag_cy;
	logic [31:0]           flag_val;

	wmie_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	// register indices for the two read slots, operand words, instruction length
	always_comb begin
		idx1 = b_q[7:0];
		case (op_q)
			wmie_pkg::OP_ST_RL, wmie_pkg::OP_ST_RR, wmie_pkg::OP_PUSH_R, wmie_pkg::OP_SAVE,
			wmie_pkg::OP_JMP_R, wmie_pkg::OP_BC_R, wmie_pkg::OP_BNC_R, wmie_pkg::OP_BZ_R,
			wmie_pkg::OP_BNZ_R, wmie_pkg::OP_BNN_R, wmie_pkg::OP_BN_R, wmie_pkg::OP_CMP_RR,
			wmie_pkg::OP_CMP_RL, wmie_pkg::OP_CALL_R, wmie_pkg::OP_OUT_R: idx1 = a_q[7:0];
			default: idx1 = b_q[7:0];
		endcase
		case (op_q)
			wmie_pkg::OP_PUSH_R, wmie_pkg::OP_PUSH_L, wmie_pkg::OP_POP: idx2 = wmie_pkg::SP_DATA;
			wmie_pkg::OP_SAVE, wmie_pkg::OP_RESTORE: idx2 = wmie_pkg::SP_SAVE;
			wmie_pkg::OP_CALL_L, wmie_pkg::OP_CALL_R, wmie_pkg::OP_RET: idx2 = wmie_pkg::SP_CALL;
			wmie_pkg::OP_ST_RR, wmie_pkg::OP_CMP_RR, wmie_pkg::OP_CMP_LR: idx2 = b_q[7:0];
			default: idx2 = c_q[7:0];
		endcase
		xv = ra_q;
		yv = rb_q;
		case (op_q)
			wmie_pkg::OP_ADD_RRL, wmie_pkg::OP_SUB_RRL, wmie_pkg::OP_XOR_RRL,
			wmie_pkg::OP_OR_RRL, wmie_pkg::OP_AND_RRL, wmie_pkg::OP_MUL_RRL,
			wmie_pkg::OP_DIV_RRL, wmie_pkg::OP_MOD_RRL, wmie_pkg::OP_SHL_RRL,
			wmie_pkg::OP_SHR_RRL: yv = c_q;
			wmie_pkg::OP_SUB_RLR, wmie_pkg::OP_DIV_RLR, wmie_pkg::OP_MOD_RLR: xv = b_q;
			wmie_pkg::OP_CMP_RL: yv = b_q;
			wmie_pkg::OP_CMP_LR: xv = a_q;
			default: ;
		endcase
		case (op_q)
			wmie_pkg::OP_RSH, wmie_pkg::OP_LSH, wmie_pkg::OP_INC, wmie_pkg::OP_DEC,
			wmie_pkg::OP_IMM, wmie_pkg::OP_MOV, wmie_pkg::OP_LOAD_L, wmie_pkg::OP_LOAD_R,
			wmie_pkg::OP_ST_LL, wmie_pkg::OP_ST_LR, wmie_pkg::OP_ST_RL, wmie_pkg::OP_ST_RR,
			wmie_pkg::OP_CMP_RR, wmie_pkg::OP_CMP_RL, wmie_pkg::OP_CMP_LR, wmie_pkg::OP_IN,
			wmie_pkg::OP_OUT_R, wmie_pkg::OP_OUT_L: len = 3'd3;
			wmie_pkg::OP_PUSH_R, wmie_pkg::OP_PUSH_L, wmie_pkg::OP_POP, wmie_pkg::OP_SAVE,
			wmie_pkg::OP_RESTORE, wmie_pkg::OP_JMP_L, wmie_pkg::OP_JMP_R, wmie_pkg::OP_BC_L,
			wmie_pkg::OP_BC_R, wmie_pkg::OP_BNC_L, wmie_pkg::OP_BNC_R, wmie_pkg::OP_BZ_L,
			wmie_pkg::OP_BZ_R, wmie_pkg::OP_BNZ_L, wmie_pkg::OP_BNZ_R, wmie_pkg::OP_BNN_L,
			wmie_pkg::OP_BNN_R, wmie_pkg::OP_BN_L, wmie_pkg::OP_BN_R, wmie_pkg::OP_CALL_L,
			wmie_pkg::OP_CALL_R: len = 3'd2;
			wmie_pkg::OP_RET, wmie_pkg::OP_HALT: len = 3'd1;
			default: len = 3'd4;
		endcase
	end

	// combinational ALU for the arithmetic, logic, shift and compare forms
	always_comb begin
		shl_wide = {32'd0, xv} << yv[4:0];
		alu_r    = '0;
		alu_cy   = 1'b0;
		is_alu   = 1'b1;
		is_cmp   = 1'b0;
		case (op_q)
			wmie_pkg::OP_ADD_RRR, wmie_pkg::OP_ADD_RRL: begin
				alu_r  = xv + yv;
				alu_cy = alu_r < xv;
			end
			wmie_pkg::OP_SUB_RRR, wmie_pkg::OP_SUB_RRL, wmie_pkg::OP_SUB_RLR: begin
				alu_r  = xv - yv;
				alu_cy = xv < yv;
			end
			wmie_pkg::OP_CMP_RR, wmie_pkg::OP_CMP_RL, wmie_pkg::OP_CMP_LR: begin
				alu_r  = xv - yv;
				alu_cy = xv < yv;
				is_cmp = 1'b1;
			end
			wmie_pkg::OP_RSH: alu_r = xv >> 1;
			wmie_pkg::OP_LSH: begin
				alu_r  = xv << 1;
				alu_cy = xv[31];
			end
			wmie_pkg::OP_INC: begin
				alu_r  = xv + 32'd1;
				alu_cy = alu_r == 32'd0;
			end
			wmie_pkg::OP_DEC: begin
				alu_r  = xv - 32'd1;
				alu_cy = xv == 32'd0;
			end
			wmie_pkg::OP_XOR_RRR, wmie_pkg::OP_XOR_RRL: alu_r = xv ^ yv;
			wmie_pkg::OP_OR_RRR, wmie_pkg::OP_OR_RRL: alu_r = xv | yv;
			wmie_pkg::OP_AND_RRR, wmie_pkg::OP_AND_RRL: alu_r = xv & yv;
			wmie_pkg::OP_SHL_RRL, wmie_pkg::OP_SHL_RRR: begin
				if (yv >= 32'd32) begin
					alu_r  = '0;
					alu_cy = xv != 32'd0;
				end else begin
					alu_r  = shl_wide[31:0];
					alu_cy = |shl_wide[63:32];
				end
			end
			wmie_pkg::OP_SHR_RRL, wmie_pkg::OP_SHR_RRR:
				alu_r = (yv >= 32'd32) ? 32'd0 : (xv >> yv[4:0]);
			default: is_alu = 1'b0;
		endcase
	end

	// branch condition and target, stack values, port decode and divider request
	always_comb begin
		is_mul  = (op_q == wmie_pkg::OP_MUL_RRR) || (op_q == wmie_pkg::OP_MUL_RRL);
		is_mod  = (op_q == wmie_pkg::OP_MOD_RRR) || (op_q == wmie_pkg::OP_MOD_RRL) ||
			(op_q == wmie_pkg::OP_MOD_RLR);
		is_div  = is_mod || (op_q == wmie_pkg::OP_DIV_RRR) || (op_q == wmie_pkg::OP_DIV_RRL) ||
			(op_q == wmie_pkg::OP_DIV_RLR);
		// jumps and branches: odd opcodes take the register form; calls are the other way
		case (op_q)
			wmie_pkg::OP_CALL_L: target = a_q;
			wmie_pkg::OP_CALL_R: target = ra_q;
			default: target = op_q[0] ? ra_q : a_q;
		endcase
		console = b_q[7:0] == wmie_pkg::CONSOLE_PORT;
		out_v   = (op_q == wmie_pkg::OP_OUT_R) ? ra_q : a_q;
		pop_ptr = rb_q + 32'd1;
		case (op_q)
			wmie_pkg::OP_PUSH_L: push_val = a_q;
			wmie_pkg::OP_CALL_L, wmie_pkg::OP_CALL_R: push_val = pc_q + 32'd2;
			default: push_val = ra_q;
		endcase
		case (op_q)
			wmie_pkg::OP_JMP_L, wmie_pkg::OP_JMP_R, wmie_pkg::OP_CALL_L,
			wmie_pkg::OP_CALL_R: take = 1'b1;
			wmie_pkg::OP_BC_L, wmie_pkg::OP_BC_R: take = fc_q;
			wmie_pkg::OP_BNC_L, wmie_pkg::OP_BNC_R: take = !fc_q;
			wmie_pkg::OP_BZ_L, wmie_pkg::OP_BZ_R: take = fz_q;
			wmie_pkg::OP_BNZ_L, wmie_pkg::OP_BNZ_R: take = !fz_q;
			wmie_pkg::OP_BNN_L, wmie_pkg::OP_BNN_R: take = !fn_q;
			wmie_pkg::OP_BN_L, wmie_pkg::OP_BN_R: take = fn_q;
			default: take = 1'b0;
		endcase
		div_req.start    = (state_q == S_EX) && is_div && (yv != 32'd0);
		div_req.dividend = xv;
		div_req.divisor  = yv;
	end

	// memory port control per sequencer step
	always_comb begin
		clr_lo   = {1'b0, clr_q} < (AW + 1)'(wmie_pkg::REG_COUNT);
		rf_raddr = (state_q == S_R2) ? idx2 : idx1;
		rf_we    = 1'b0;
		rf_waddr = a_q[7:0];
		rf_wdata = '0;
		dm_we    = 1'b0;
		dm_addr  = b_q[AW-1:0];
		dm_wdata = '0;
		pl_we    = 1'b0;
		pl_addr  = b_q[7:0];
		pl_wdata = '0;
		flag_we  = 1'b0;
		flag_val = alu_r;
		flag_cy  = alu_cy;
		case (state_q)
			S_CLR: begin
				rf_we    = clr_lo;
				rf_waddr = clr_q[7:0];
				pl_we    = clr_lo;
				pl_addr  = clr_q[7:0];
				dm_we    = 1'b1;
				dm_addr  = clr_q;
			end
			S_EX: begin
				if (is_alu) begin
					rf_we    = !is_cmp;
					rf_wdata = alu_r;
					flag_we  = 1'b1;
				end
				case (op_q)
					wmie_pkg::OP_IMM: begin
						rf_we    = 1'b1;
						rf_wdata = b_q;
					end
					wmie_pkg::OP_MOV: begin
						rf_we    = 1'b1;
						rf_wdata = ra_q;
					end
					wmie_pkg::OP_LOAD_R: dm_addr = ra_q[AW-1:0];
					wmie_pkg::OP_ST_LL, wmie_pkg::OP_ST_LR: begin
						dm_we    = 1'b1;
						dm_addr  = a_q[AW-1:0];
						dm_wdata = (op_q == wmie_pkg::OP_ST_LL) ? b_q : ra_q;
					end
					wmie_pkg::OP_ST_RL, wmie_pkg::OP_ST_RR: begin
						dm_we    = 1'b1;
						dm_addr  = ra_q[AW-1:0];
						dm_wdata = (op_q == wmie_pkg::OP_ST_RL) ? b_q : rb_q;
					end
					wmie_pkg::OP_PUSH_R, wmie_pkg::OP_PUSH_L, wmie_pkg::OP_SAVE,
					wmie_pkg::OP_CALL_L, wmie_pkg::OP_CALL_R: begin
						dm_we    = 1'b1;
						dm_addr  = rb_q[AW-1:0];
						dm_wdata = push_val;
						rf_we    = 1'b1;
						rf_waddr = idx2;
						rf_wdata = rb_q - 32'd1;
					end
					wmie_pkg::OP_POP, wmie_pkg::OP_RESTORE, wmie_pkg::OP_RET: begin
						dm_addr  = pop_ptr[AW-1:0];
						rf_we    = 1'b1;
						rf_waddr = idx2;
						rf_wdata = pop_ptr;
					end
					wmie_pkg::OP_IN: begin
						pl_we    = console;
						pl_wdata = {24'd0, key_q};
					end
					wmie_pkg::OP_OUT_R, wmie_pkg::OP_OUT_L: begin
						pl_we    = 1'b1;
						pl_wdata = out_v;
					end
					default: ;
				endcase
			end
			S_LD: begin
				rf_we = op_q != wmie_pkg::OP_RET;
				if (op_q == wmie_pkg::OP_IN) begin
					rf_wdata = console ? {24'd0, key_q} : pl_rdata_q;
				end else begin
					rf_wdata = dm_rdata_q;
				end
			end
			S_MUL: begin
				rf_we    = 1'b1;
				rf_wdata = prod_q[31:0];
				flag_we  = 1'b1;
				flag_val = prod_q[31:0];
				flag_cy  = |prod_q[63:32];
			end
			S_DIV: begin
				rf_we    = div_res.done;
				rf_wdata = is_mod ? div_res.rem : div_res.quot;
				flag_we  = div_res.done;
				flag_val = rf_wdata;
				flag_cy  = 1'b0;
			end
			default: ;
		endcase
	end

	// register file, port latches and data memory
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[rf_waddr] <= rf_wdata;
		end
		rf_rdata_q <= rf_mem[rf_raddr];
	end

	always_ff @(posedge clk) begin
		if (pl_we) begin
			pl_mem[pl_addr] <= pl_wdata;
		end
		pl_rdata_q <= pl_mem[pl_addr];
	end

	always_ff @(posedge clk) begin
		if (dm_we) begin
			dm_mem[dm_addr] <= dm_wdata;
		end
		dm_rdata_q <= dm_mem[dm_addr];
	end

	// sequencer, flags, program address and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			pc_q       <= '0;
			fz_q       <= 1'b1;
			fc_q       <= 1'b0;
			fn_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (flag_we) begin
				fz_q <= flag_val == 32'd0;
				fc_q <= flag_cy;
				fn_q <= (flag_val & wmie_pkg::SIGN_BIT) != 32'd0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(wmie_pkg::MEM_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= wmie_pkg::opcode_t'(s_tdata[5:0]);
						a_q     <= s_tdata[37:6];
						b_q     <= s_tdata[69:38];
						c_q     <= s_tdata[101:70];
						key_q   <= s_tdata[109:102];
						halt_q  <= 1'b0;
						pv_q    <= 1'b0;
						pval_q  <= '0;
						kt_q    <= 1'b0;
						fault_q <= 1'b0;
						state_q <= S_R1;
					end
				end
				S_R1: state_q <= S_R2;
				S_R2: begin
					ra_q    <= rf_rdata_q;
					state_q <= S_R3;
				end
				S_R3: begin
					rb_q    <= rf_rdata_q;
					state_q <= S_EX;
				end
				S_EX: begin
					next_q  <= take ? target : pc_q + {29'd0, len};
					state_q <= S_DONE;
					if (is_mul) begin
						prod_q  <= {32'd0, xv} * {32'd0, yv};
						state_q <= S_MUL;
					end
					if (is_div) begin
						if (yv == 32'd0) begin
							fault_q <= 1'b1;
						end else begin
							state_q <= S_DIV;
						end
					end
					case (op_q)
						wmie_pkg::OP_LOAD_L, wmie_pkg::OP_LOAD_R, wmie_pkg::OP_POP,
						wmie_pkg::OP_RESTORE, wmie_pkg::OP_RET: state_q <= S_LD;
						wmie_pkg::OP_IN: begin
							kt_q    <= console;
							state_q <= S_LD;
						end
						wmie_pkg::OP_OUT_R, wmie_pkg::OP_OUT_L: begin
							pv_q   <= console;
							pval_q <= console ? out_v : 32'd0;
						end
						wmie_pkg::OP_HALT: halt_q <= 1'b1;
						default: ;
					endcase
				end
				S_LD: begin
					if (op_q == wmie_pkg::OP_RET) begin
						next_q <= dm_rdata_q;
					end
					state_q <= S_DONE;
				end
				S_MUL: state_q <= S_DONE;
				S_DIV: begin
					if (div_res.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {1'b0, fn_q, fc_q, fz_q, fault_q, kt_q, pval_q, pv_q,
							halt_q, next_q};
						pc_q       <= next_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// divider finishes only while the sequencer waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIV)
		else $error("divider done outside divide wait");

	// no instruction during the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !s_tready)
		else $error("input ready during memory clear");

	// a new result is loaded only from the final step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == S_DONE)
		else $error("result loaded outside final step");

	// an accepted instruction always starts with the register reads
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_R1)
		else $error("accept did not start operand reads");

endmodule
`default_nettype wire

@@ hw/rtl/wmie_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module wmie_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wmie_pkg::div_req_t req,
	output wmie_pkg::div_res_t     res
);

	logic                           busy_q;
	logic                           done_q;
	logic [wmie_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [wmie_pkg::WORD_W-1:0]    rem_q;
	logic [wmie_pkg::WORD_W-1:0]    quo_q;
	logic [wmie_pkg::WORD_W-1:0]    dvs_q;
	logic [wmie_pkg::WORD_W:0]      shifted;
	logic [wmie_pkg::WORD_W:0]      diff;
	logic                           ge;

	// trial subtract of the shifted partial remainder
	always_comb begin
		shifted = {rem_q, quo_q[wmie_pkg::WORD_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = !diff[wmie_pkg::WORD_W];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == wmie_pkg::DIV_CNT_W'(wmie_pkg::WORD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[wmie_pkg::WORD_W-1:0] : shifted[wmie_pkg::WORD_W-1:0];
			quo_q <= {quo_q[wmie_pkg::WORD_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule
`default_nettype wire
